>>> sv/cema_pkg.sv
// Package of the cascaded EMA position smoother: widths, constants,
// sequencer state type, register indexes and the store control struct.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package cema_pkg;

    localparam int MAX_STAGES_DEF = 3;
    localparam int POS_W          = 32;
    localparam int STR_W          = 17;
    localparam int VF_W           = 16;
    localparam int SC_W           = 2;
    localparam int CFG_W          = 17;
    localparam int CFG_IDX_W      = 2;
    localparam int ALPHA_W        = 17;
    localparam int MUL_A_W        = ALPHA_W + 1;
    localparam int MUL_B_W        = POS_W + 1;
    localparam int PROD_W         = MUL_A_W + MUL_B_W;
    localparam int ACC_W          = POS_W + 4;
    localparam int AXIS_W         = 2;
    localparam int FRAC_W         = 16;

    localparam logic [ALPHA_W-1:0] ONE_Q16 = ALPHA_W'(65536);
    localparam logic [VF_W-1:0]    VF_RESET = VF_W'(256);
    localparam logic [SC_W-1:0]    SC_RESET = SC_W'(1);

    localparam logic [AXIS_W-1:0] AXIS_X = AXIS_W'(0);
    localparam logic [AXIS_W-1:0] AXIS_Y = AXIS_W'(1);
    localparam logic [AXIS_W-1:0] AXIS_Z = AXIS_W'(2);

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STRENGTH = 2'd0,
        REG_VFACTOR  = 2'd1,
        REG_STAGES   = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALPHA,
        ST_ALPHA_Y,
        ST_MUL,
        ST_ADD,
        ST_ACC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              load_all;
        logic              wr;
        logic [AXIS_W-1:0] axis;
    } t_store_ctl;

endpackage

`default_nettype wire

>>> sv/cema_in_if.sv
// Input channel of the smoother: valid, ready and one position request.
// Depends on cema_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cema_in_if;
    logic                             valid;
    logic                             ready;
    logic                             op;
    logic signed [cema_pkg::POS_W-1:0] pos_x;
    logic signed [cema_pkg::POS_W-1:0] pos_y;
    logic signed [cema_pkg::POS_W-1:0] pos_z;

    modport source (output valid, output op, output pos_x, output pos_y, output pos_z,
                    input ready);
    modport sink   (input valid, input op, input pos_x, input pos_y, input pos_z,
                    output ready);
endinterface

`default_nettype wire

>>> sv/cema_out_if.sv
// Output channel of the smoother: valid, ready and one smoothed position.
// Depends on cema_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cema_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [cema_pkg::POS_W-1:0] out_x;
    logic signed [cema_pkg::POS_W-1:0] out_y;
    logic signed [cema_pkg::POS_W-1:0] out_z;

    modport source (output valid, output out_x, output out_y, output out_z, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

`default_nettype wire

>>> sv/cascaded_ema_position_smoother_core.sv
// Top level of the cascaded EMA position smoother: configuration registers,
// the stage sequencer and the result register. Depends on cema_pkg,
// cema_in_if, cema_out_if, cema_mac and cema_store.
`timescale 1ns / 1ps
`default_nettype none

// A filter request runs on the one multiplier and rounding adder that
// serve every stage of every axis in turn, three steps per stage
// (multiply, round and store, accumulate), after the states ST_ALPHA and
// ST_ALPHA_Y that derive the alphas; ST_DONE then moves the result to the
// output register and the block goes back to idle, where the next request
// is taken. A reset request loads the stage store and stays in idle. The
// block takes no request while a filter request is at work, and it waits
// with a finished result only while the previous one has not been taken.
module cascaded_ema_position_smoother_core #(
    parameter int MAX_STAGES = cema_pkg::MAX_STAGES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [cema_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [cema_pkg::CFG_W-1:0]      i_cfg_data,
    cema_in_if.sink                              i_in,
    cema_out_if.source                           o_out
);

    localparam int STG_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int PW    = cema_pkg::PROD_W;
    localparam int AW    = cema_pkg::ALPHA_W;
    localparam int ACW   = cema_pkg::ACC_W;
    localparam int PSW   = cema_pkg::POS_W;

    localparam logic signed [ACW-1:0] SAT_MAX = ACW'(64'sh7FFFFFFF);
    localparam logic signed [ACW-1:0] SAT_MIN = -ACW'(64'sh80000000);

    logic [cema_pkg::STR_W-1:0] r_strength;
    logic [cema_pkg::VF_W-1:0]  r_vfactor;
    logic [cema_pkg::SC_W-1:0]  r_stages;

    cema_pkg::t_state r_state, n_state;
    logic [cema_pkg::AXIS_W-1:0] r_axis, n_axis;
    logic [STG_W-1:0]            r_stg, n_stg;
    logic [STG_W-1:0]            r_last_stg, n_last_stg;
    logic [AW-1:0]               r_alpha_xz, n_alpha_xz;
    logic [AW-1:0]               r_alpha_y, n_alpha_y;
    logic signed [PSW-1:0]       r_cur, n_cur;
    logic signed [PSW-1:0]       r_pos [3];
    logic signed [PSW-1:0]       n_pos [3];
    logic signed [ACW-1:0]       r_acc, n_acc;
    logic signed [PSW-1:0]       r_res [3];
    logic signed [PSW-1:0]       n_res [3];
    logic                        r_out_valid, n_out_valid;
    logic signed [PSW-1:0]       r_out_x, n_out_x;
    logic signed [PSW-1:0]       r_out_y, n_out_y;
    logic signed [PSW-1:0]       r_out_z, n_out_z;

    logic signed [cema_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [cema_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [PW-1:0]                w_prod;
    logic signed [PSW-1:0]               w_round;
    logic signed [PSW-1:0]               w_stored;
    cema_pkg::t_store_ctl                w_ctl;

    logic                        w_in_acc;
    logic [AW-1:0]               w_str_c;
    logic [PW-9:0]               w_scaled;
    logic [cema_pkg::SC_W-1:0]   w_eff;
    logic signed [ACW-1:0]       w_v, w_v2, w_v3, w_term, w_acc_next;
    logic signed [PSW-1:0]       w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength <= '0;
            r_vfactor  <= cema_pkg::VF_RESET;
            r_stages   <= cema_pkg::SC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cema_pkg::REG_STRENGTH: r_strength <= i_cfg_data;
                cema_pkg::REG_VFACTOR:  r_vfactor  <= i_cfg_data[cema_pkg::VF_W-1:0];
                cema_pkg::REG_STAGES:   r_stages   <= i_cfg_data[cema_pkg::SC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_in_acc = i_in.valid && i_in.ready;
        w_str_c  = (r_strength > cema_pkg::ONE_Q16) ? cema_pkg::ONE_Q16 : r_strength;
        w_scaled = w_prod[PW-1:8];
        w_eff    = (r_stages == '0) ? cema_pkg::SC_W'(1) : r_stages;
        if (32'(w_eff) > MAX_STAGES) begin
            w_eff = cema_pkg::SC_W'(MAX_STAGES);
        end

        w_v  = ACW'(r_cur);
        w_v2 = w_v <<< 1;
        w_v3 = w_v2 + w_v;
        if (r_last_stg == '0) begin
            w_term = w_v;
        end else if (r_last_stg == STG_W'(1)) begin
            w_term = (r_stg == '0) ? w_v2 : -w_v;
        end else begin
            w_term = (r_stg == '0) ? w_v3 : ((r_stg == STG_W'(1)) ? -w_v3 : w_v);
        end
        w_acc_next = r_acc + w_term;
        if (w_acc_next > SAT_MAX) begin
            w_sat = PSW'(SAT_MAX);
        end else if (w_acc_next < SAT_MIN) begin
            w_sat = PSW'(SAT_MIN);
        end else begin
            w_sat = w_acc_next[PSW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cema_pkg::ST_IDLE;
            r_axis      <= '0;
            r_stg       <= '0;
            r_last_stg  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_stg       <= n_stg;
            r_last_stg  <= n_last_stg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_alpha_xz <= n_alpha_xz;
        r_alpha_y  <= n_alpha_y;
        r_cur      <= n_cur;
        r_acc      <= n_acc;
        r_pos      <= n_pos;
        r_res      <= n_res;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_z    <= n_out_z;
    end

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_stg       = r_stg;
        n_last_stg  = r_last_stg;
        n_alpha_xz  = r_alpha_xz;
        n_alpha_y   = r_alpha_y;
        n_cur       = r_cur;
        n_acc       = r_acc;
        n_pos       = r_pos;
        n_res       = r_res;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_z     = r_out_z;
        n_out_valid = r_out_valid && !o_out.ready;
        i_in.ready  = 1'b0;
        w_ctl       = '{load_all: 1'b0, wr: 1'b0, axis: r_axis};
        w_mul_a     = {1'b0, ((r_axis == cema_pkg::AXIS_Y) ? r_alpha_y : r_alpha_xz)};
        w_mul_b     = {r_cur[PSW-1], r_cur} - {w_stored[PSW-1], w_stored};

        unique case (r_state)
            cema_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (w_in_acc) begin
                    if (i_in.op == cema_pkg::OP_RESET) begin
                        w_ctl.load_all = 1'b1;
                    end else begin
                        n_pos[0]   = i_in.pos_x;
                        n_pos[1]   = i_in.pos_y;
                        n_pos[2]   = i_in.pos_z;
                        n_last_stg = STG_W'(w_eff - cema_pkg::SC_W'(1));
                        n_axis     = cema_pkg::AXIS_X;
                        n_stg      = '0;
                        n_state    = cema_pkg::ST_ALPHA;
                    end
                end
            end
            cema_pkg::ST_ALPHA: begin
                w_mul_a    = {1'b0, w_str_c};
                w_mul_b    = {{(cema_pkg::MUL_B_W - cema_pkg::VF_W){1'b0}}, r_vfactor};
                n_alpha_xz = cema_pkg::ONE_Q16 - w_str_c;
                n_state    = cema_pkg::ST_ALPHA_Y;
            end
            cema_pkg::ST_ALPHA_Y: begin
                if (w_scaled > (PW-8)'(cema_pkg::ONE_Q16)) begin
                    n_alpha_y = '0;
                end else begin
                    n_alpha_y = cema_pkg::ONE_Q16 - w_scaled[AW-1:0];
                end
                n_cur   = r_pos[0];
                n_acc   = '0;
                n_state = cema_pkg::ST_MUL;
            end
            cema_pkg::ST_MUL: begin
                n_state = cema_pkg::ST_ADD;
            end
            cema_pkg::ST_ADD: begin
                w_ctl.wr = 1'b1;
                n_cur    = w_round;
                n_state  = cema_pkg::ST_ACC;
            end
            cema_pkg::ST_ACC: begin
                n_acc = w_acc_next;
                if (r_stg == r_last_stg) begin
                    n_res[r_axis] = w_sat;
                    n_stg         = '0;
                    if (r_axis == cema_pkg::AXIS_Z) begin
                        n_state = cema_pkg::ST_DONE;
                    end else begin
                        n_axis  = r_axis + cema_pkg::AXIS_W'(1);
                        n_cur   = r_pos[r_axis + cema_pkg::AXIS_W'(1)];
                        n_acc   = '0;
                        n_state = cema_pkg::ST_MUL;
                    end
                end else begin
                    n_stg   = r_stg + STG_W'(1);
                    n_state = cema_pkg::ST_MUL;
                end
            end
            cema_pkg::ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_x     = r_res[0];
                    n_out_y     = r_res[1];
                    n_out_z     = r_res[2];
                    n_out_valid = 1'b1;
                    n_state     = cema_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cema_pkg::ST_IDLE;
            end
        endcase
    end

    cema_mac u_mac (
        .i_clk    (i_clk),
        .i_mul_a  (w_mul_a),
        .i_mul_b  (w_mul_b),
        .i_stored (w_stored),
        .o_prod   (w_prod),
        .o_round  (w_round)
    );

    cema_store #(
        .MAX_STAGES (MAX_STAGES),
        .STG_W      (STG_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_stg    (r_stg),
        .i_wdata  (w_round),
        .i_load_x (i_in.pos_x),
        .i_load_y (i_in.pos_y),
        .i_load_z (i_in.pos_z),
        .o_rdata  (w_stored)
    );

    assign o_out.valid = r_out_valid;
    assign o_out.out_x = r_out_x;
    assign o_out.out_y = r_out_y;
    assign o_out.out_z = r_out_z;

`ifndef SYNTHESIS
    a_stage_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != cema_pkg::ST_IDLE) |-> (r_stg <= r_last_stg))
        else $error("stage counter ran past the active stage count");

    a_filter_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.op == cema_pkg::OP_FILTER)) |=> (r_state == cema_pkg::ST_ALPHA))
        else $error("accepted filter request did not start the sequencer");

    a_reset_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.op == cema_pkg::OP_RESET)) |=> (r_state == cema_pkg::ST_IDLE))
        else $error("reset request started the sequencer");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == cema_pkg::ST_DONE) && !r_out_valid)
            |=> (r_out_valid && (r_state == cema_pkg::ST_IDLE)))
        else $error("finished result not moved to the output register");
`endif

endmodule

`default_nettype wire

>>> sv/cema_mac.sv
// Shared arithmetic unit: one registered signed multiplier and the
// rounding adder that forms a stage value from the product.
// Depends on cema_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cema_mac (
    input  wire logic                                  i_clk,
    input  wire logic signed [cema_pkg::MUL_A_W-1:0]   i_mul_a,
    input  wire logic signed [cema_pkg::MUL_B_W-1:0]   i_mul_b,
    input  wire logic signed [cema_pkg::POS_W-1:0]     i_stored,
    output logic signed [cema_pkg::PROD_W-1:0]         o_prod,
    output logic signed [cema_pkg::POS_W-1:0]          o_round
);

    localparam int PW = cema_pkg::PROD_W;
    localparam int FW = cema_pkg::FRAC_W;
    localparam int HI = cema_pkg::POS_W + FW;

    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] w_base;
    logic signed [PW-1:0] w_sum;

    always_ff @(posedge i_clk) begin
        r_prod <= i_mul_a * i_mul_b;
    end

    // The stage value is (stored * 2^16 + alpha * (current - stored)) / 2^16, rounded half up.
    always_comb begin
        w_base  = {{(PW-HI){i_stored[cema_pkg::POS_W-1]}}, i_stored, {FW{1'b0}}};
        w_sum   = w_base + r_prod + PW'(32768);
        o_round = w_sum[HI-1:FW];
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

>>> sv/cema_store.sv
// Stage value store: one Q16.16 value per stage and axis, reset to zero,
// loaded as a whole by a reset request and written one entry at a time.
// Depends on cema_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cema_store #(
    parameter int MAX_STAGES = cema_pkg::MAX_STAGES_DEF,
    parameter int STG_W      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire cema_pkg::t_store_ctl              i_ctl,
    input  wire logic [STG_W-1:0]                  i_stg,
    input  wire logic signed [cema_pkg::POS_W-1:0] i_wdata,
    input  wire logic signed [cema_pkg::POS_W-1:0] i_load_x,
    input  wire logic signed [cema_pkg::POS_W-1:0] i_load_y,
    input  wire logic signed [cema_pkg::POS_W-1:0] i_load_z,
    output logic signed [cema_pkg::POS_W-1:0]      o_rdata
);

    logic signed [cema_pkg::POS_W-1:0] r_val [MAX_STAGES][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < MAX_STAGES; s++) begin
                for (int a = 0; a < 3; a++) begin
                    r_val[s][a] <= '0;
                end
            end
        end else if (i_ctl.load_all) begin
            for (int s = 0; s < MAX_STAGES; s++) begin
                r_val[s][0] <= i_load_x;
                r_val[s][1] <= i_load_y;
                r_val[s][2] <= i_load_z;
            end
        end else if (i_ctl.wr) begin
            r_val[i_stg][i_ctl.axis] <= i_wdata;
        end
    end

    assign o_rdata = r_val[i_stg][i_ctl.axis];

`ifndef SYNTHESIS
    a_no_load_and_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.load_all && i_ctl.wr))
        else $error("stage store loaded and written in the same cycle");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.wr |-> (i_ctl.axis != 2'd3) && (32'(i_stg) < MAX_STAGES))
        else $error("stage store written outside its entries");

    a_load_takes_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load_all |=> r_val[MAX_STAGES-1][0] == $past(i_load_x))
        else $error("reset request did not reach the last stage");
`endif

endmodule

`default_nettype wire
